### rtl/assert_macros.svh
// Assertion helpers included by the PWM engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lfx_pkg.sv
package lfx_pkg;

    localparam int NUM_CH = 4;
    localparam int PHASE_W = 6;
    localparam int DIV_W = 10;
    localparam int LEVEL_W = 8;
    localparam int WORD_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0] WORD_RESET = 16'h1F30;
    localparam logic [DIV_W-1:0] DIV_RESET = 10'd200;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_LED0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LED1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LED2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LED3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 3'd4;

    // Effect modes
    localparam logic [3:0] MODE_OFF = 4'd0;
    localparam logic [3:0] MODE_ON = 4'd1;
    localparam logic [3:0] MODE_BLINK = 4'd2;
    localparam logic [3:0] MODE_FADE = 4'd3;
    localparam logic [3:0] MODE_INV_A = 4'd4;
    localparam logic [3:0] MODE_INV_B = 4'd5;
    localparam logic [3:0] MODE_SYNC_A = 4'd6;
    localparam logic [3:0] MODE_MIX = 4'd7;

    typedef logic [LEVEL_W-1:0] t_level;

    typedef struct packed {
        t_level step;
        t_level fade;
        t_level level;
    } t_chan_state;

    // Channel whose level a follow mode watches.
    function automatic logic [1:0] follow_src(logic [1:0] ch, logic [3:0] mode);
        logic [1:0] src;
        src = 2'd1;
        case (mode)
            MODE_INV_A, MODE_SYNC_A: begin
                src = (ch == 2'd1) ? 2'd2 : 2'd1;
            end
            MODE_INV_B, MODE_MIX: begin
                src = (ch == 2'd3) ? 2'd2 : 2'd3;
            end
            default: begin
                src = 2'd1;
            end
        endcase
        return src;
    endfunction

    // One effect step of one channel; x is the watched channel's level.
    function automatic t_chan_state chan_update(logic [WORD_W-1:0] word, t_chan_state cur,
                                                logic [1:0] ch, t_level x);
        t_chan_state nxt;
        t_level br;
        logic [3:0] mode;
        logic [4:0] per;
        t_level s;
        t_level f;
        logic [8:0] twice_b;
        logic lit;
        logic on_zero;
        br = word[15:8];
        mode = word[7:4];
        per = {1'b0, word[3:0]} + 5'd1;
        nxt = cur;
        lit = 1'b0;
        on_zero = 1'b0;
        f = cur.fade;
        twice_b = {br, 1'b0};

        // Step counter wraps past twice the period
        s = cur.step + 8'd1;
        if (s > {2'b00, per, 1'b0}) begin
            s = '0;
        end
        nxt.step = s;

        case (mode)
            MODE_OFF: begin
                nxt.level = '0;
            end
            MODE_ON: begin
                nxt.level = br;
            end
            MODE_BLINK: begin
                nxt.level = (s < {3'b000, per}) ? br : '0;
            end
            MODE_FADE: begin
                if (s == '0 || s == {3'b000, per}) begin
                    f = cur.fade + 8'd1;
                    if ({1'b0, f} >= twice_b) begin
                        f = '0;
                    end
                    nxt.fade = f;
                    nxt.level = (f < br) ? f : LEVEL_W'(twice_b - {1'b0, f});
                end
            end
            MODE_INV_A, MODE_INV_B, MODE_SYNC_A, MODE_MIX: begin
                if (ch != 2'd0) begin
                    case (mode)
                        MODE_INV_A, MODE_INV_B: on_zero = 1'b1;
                        MODE_MIX: on_zero = (ch == 2'd1);
                        default: on_zero = 1'b0;
                    endcase
                    lit = on_zero ? (x == '0) : (x != '0);
                    nxt.level = lit ? br : '0;
                end
            end
            default: begin
                nxt.level = cur.level;
            end
        endcase
        return nxt;
    endfunction

endpackage

### rtl/led_effect_pwm_engine.sv
// Four-channel LED PWM engine with effect sequencer.
// The LED bits of an accepted tick are loaded into the output register as it is accepted.
// Throughput: one tick per cycle while not stalled; the four-channel effect chain is combinational.
// Input stalls only while the output register is full and its consumer stalls.
// Reset (synchronous, active low): phase, counters and levels clear, out valid drops,
// control words return to 0x1F30 and the divider to 200; LED bits are not reset.
module led_effect_pwm_engine #(
    parameter int PWM_TOP = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_advance,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_led0_on,
    output logic        o_led1_on,
    output logic        o_led2_on,
    output logic        o_led3_on,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int NCH = lfx_pkg::NUM_CH;
    localparam logic [lfx_pkg::PHASE_W:0] PHASE_TOP = (lfx_pkg::PHASE_W + 1)'(PWM_TOP);

    logic [lfx_pkg::WORD_W-1:0] r_word [NCH];
    logic [lfx_pkg::DIV_W-1:0]  r_divider;
    logic [lfx_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [lfx_pkg::DIV_W-1:0]  r_div_count, n_div_count;
    lfx_pkg::t_chan_state       r_chan [NCH];
    lfx_pkg::t_chan_state       n_chan [NCH];
    logic                       r_out_valid;
    logic [NCH-1:0]             r_led, n_led;

    logic                       accept;
    logic                       update_hit;
    logic [lfx_pkg::PHASE_W:0]  phase_inc;
    logic [lfx_pkg::DIV_W:0]    div_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_word[i] <= lfx_pkg::WORD_RESET;
            end
            r_divider <= lfx_pkg::DIV_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lfx_pkg::REG_LED0:    r_word[0] <= i_cfg_data;
                lfx_pkg::REG_LED1:    r_word[1] <= i_cfg_data;
                lfx_pkg::REG_LED2:    r_word[2] <= i_cfg_data;
                lfx_pkg::REG_LED3:    r_word[3] <= i_cfg_data;
                lfx_pkg::REG_DIVIDER: r_divider <= i_cfg_data[lfx_pkg::DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // Phase and divider counters
    always_comb begin
        phase_inc = {1'b0, r_phase} + 1'b1;
        n_phase = r_phase;
        if (i_advance) begin
            n_phase = (phase_inc > PHASE_TOP) ? '0 : phase_inc[lfx_pkg::PHASE_W-1:0];
        end
        div_inc = {1'b0, r_div_count} + 1'b1;
        update_hit = i_advance && (div_inc >= {1'b0, r_divider});
        n_div_count = r_div_count;
        if (i_advance) begin
            n_div_count = update_hit ? '0 : div_inc[lfx_pkg::DIV_W-1:0];
        end
    end

    // LED bits compare current levels with the next phase
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            n_led[i] = r_chan[i].level > {2'b00, n_phase};
        end
    end

    // Effect update in channel order; a watched lower channel gives its new level, a higher one its registered level
    always_comb begin
        lfx_pkg::t_level lv [NCH];
        lfx_pkg::t_level x;
        for (int i = 0; i < NCH; i++) begin
            lv[i] = r_chan[i].level;
        end
        for (int i = 0; i < NCH; i++) begin
            x = lv[lfx_pkg::follow_src(2'(i), r_word[i][7:4])];
            n_chan[i] = lfx_pkg::chan_update(r_word[i], r_chan[i], 2'(i), x);
            lv[i] = n_chan[i].level;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_div_count <= '0;
            for (int i = 0; i < NCH; i++) begin
                r_chan[i] <= '0;
            end
        end else if (accept) begin
            r_phase <= n_phase;
            r_div_count <= n_div_count;
            if (update_hit) begin
                for (int i = 0; i < NCH; i++) begin
                    r_chan[i] <= n_chan[i];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_led <= n_led;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led0_on = r_led[0];
    assign o_led1_on = r_led[1];
    assign o_led2_on = r_led[2];
    assign o_led3_on = r_led[3];

    // Checks
    `ASSERT_ALWAYS(a_phase_range, {1'b0, r_phase} <= PHASE_TOP, "phase beyond PWM top")
    `ASSERT_NEXT(a_report_holds, accept && !i_advance,
        $stable(r_phase) && $stable(r_div_count), "report-only beat changed counters")
    `ASSERT_ALWAYS(a_step_range,
        r_chan[0].step <= 8'd32 && r_chan[1].step <= 8'd32 &&
        r_chan[2].step <= 8'd32 && r_chan[3].step <= 8'd32, "step count out of range")

endmodule
